// File: sv/pngenc_pkg.sv
`default_nettype none
package pngenc_pkg;

  localparam logic [31:0] CrcPoly  = 32'hEDB88320;
  localparam logic [31:0] CrcInit  = 32'hFFFFFFFF;
  localparam logic [16:0] AdlerMod = 17'd65521;
  localparam logic [15:0] BlockMax = 16'hFFFF;

  typedef struct packed {
    logic [31:0] pixel;
    logic        kind;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_image;
  } out_word_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] pixel;
  } cmd_t;

  // One byte through the reflected CRC-32 register.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/pngenc_front.sv
`default_nettype none
module pngenc_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push,
  output logic                 full,
  input  pngenc_pkg::in_word_t in_word_i,
  output logic                 cmd_valid_o,
  output pngenc_pkg::cmd_t     cmd_o,
  input  wire                  cmd_take_i
);
  import pngenc_pkg::*;

  // two-entry command queue
  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       wr, rd;
  cmd_t       cmd_new;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rptr_q];
  assign wr          = push && !full;
  assign rd          = cmd_take_i && cmd_valid_o;

  always_comb begin
    cmd_new.pixel = in_word_i.pixel;
    cmd_new.kind  = in_word_i.kind ? CMD_PIXEL : CMD_START;
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
`default_nettype wire

// File: sv/pngenc_back.sv
`default_nettype none
module pngenc_back #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire  [12:0]           image_width_i,
  input  wire  [12:0]           image_height_i,
  input  wire                   cmd_valid_i,
  input  pngenc_pkg::cmd_t      cmd_i,
  output logic                  cmd_take_o,
  output logic                  empty,
  input  wire                   pop,
  output pngenc_pkg::out_word_t out_word_o
);
  import pngenc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_LEN, ST_HDR, ST_DATA, ST_BLK, ST_END
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  idx_q, idx_d;
  logic [2:0]  j_q, j_d;
  logic [31:0] pix_q, pix_d;
  logic [15:0] fw_q, fw_d, fh_q, fh_d;
  logic [31:0] total_q, total_d;
  logic [16:0] blocks_q, blocks_d;
  logic [31:0] idat_q, idat_d;
  logic [31:0] crc_q, crc_d;
  logic [15:0] lo_q, lo_d, hi_q, hi_d;
  logic [15:0] col_q, col_d;
  logic [15:0] blk_q, blk_d;
  logic [31:0] strm_q, strm_d;
  logic        act_q, act_d;
  logic        oval_q, oval_d;
  out_word_t   ow_q, ow_d;

  logic        out_free;
  logic [7:0]  hb, db, bb, eb;
  logic        fin;
  logic [15:0] blen;
  logic [32:0] dx;
  logic [16:0] q0, q1, q2;
  logic [17:0] r0, r1;
  logic [16:0] lo_sum, hi_sum;
  logic [15:0] lo_n, hi_n;
  logic [16:0] col_inc;
  logic [31:0] nc;

  assign out_free   = !oval_q || pop;
  assign empty      = !oval_q;
  assign out_word_o = ow_q;
  assign nc         = ~crc_q;

  // start header bytes
  always_comb begin
    case (idx_q)
      6'd0: hb = 8'h89;  6'd1: hb = 8'h50;  6'd2: hb = 8'h4E;  6'd3: hb = 8'h47;
      6'd4: hb = 8'h0D;  6'd5: hb = 8'h0A;  6'd6: hb = 8'h1A;  6'd7: hb = 8'h0A;
      6'd11: hb = 8'h0D;
      6'd12: hb = 8'h49; 6'd13: hb = 8'h48; 6'd14: hb = 8'h44; 6'd15: hb = 8'h52;
      6'd18: hb = fw_q[15:8]; 6'd19: hb = fw_q[7:0];
      6'd22: hb = fh_q[15:8]; 6'd23: hb = fh_q[7:0];
      6'd24: hb = 8'h08; 6'd25: hb = 8'h06;
      6'd29: hb = nc[31:24]; 6'd30: hb = nc[23:16]; 6'd31: hb = nc[15:8]; 6'd32: hb = nc[7:0];
      6'd33: hb = idat_q[31:24]; 6'd34: hb = idat_q[23:16];
      6'd35: hb = idat_q[15:8];  6'd36: hb = idat_q[7:0];
      6'd37: hb = 8'h49; 6'd38: hb = 8'h44; 6'd39: hb = 8'h41; 6'd40: hb = 8'h54;
      6'd41: hb = 8'h78; 6'd42: hb = 8'h01;
      default: hb = 8'h00;
    endcase
  end

  // filter byte then R,G,B,A
  always_comb begin
    case (j_q)
      3'd1: db = pix_q[7:0];
      3'd2: db = pix_q[15:8];
      3'd3: db = pix_q[23:16];
      3'd4: db = pix_q[31:24];
      default: db = 8'h00;
    endcase
  end

  // stored block header
  assign fin  = (strm_q <= {16'h0, BlockMax});
  assign blen = fin ? strm_q[15:0] : BlockMax;
  always_comb begin
    case (idx_q)
      6'd0: bb = {7'h0, fin};
      6'd1: bb = blen[7:0];
      6'd2: bb = blen[15:8];
      6'd3: bb = ~blen[7:0];
      default: bb = ~blen[15:8];
    endcase
  end

  // trailer: Adler-32, IDAT CRC, IEND chunk
  always_comb begin
    case (idx_q)
      6'd0: eb = hi_q[15:8]; 6'd1: eb = hi_q[7:0];
      6'd2: eb = lo_q[15:8]; 6'd3: eb = lo_q[7:0];
      6'd4: eb = nc[31:24];  6'd5: eb = nc[23:16]; 6'd6: eb = nc[15:8]; 6'd7: eb = nc[7:0];
      6'd12: eb = 8'h49; 6'd13: eb = 8'h45; 6'd14: eb = 8'h4E; 6'd15: eb = 8'h44;
      6'd16: eb = nc[31:24]; 6'd17: eb = nc[23:16]; 6'd18: eb = nc[15:8]; 6'd19: eb = nc[7:0];
      default: eb = 8'h00;
    endcase
  end

  // ceil(total / 65535) by folding the upper half
  always_comb begin
    dx = {1'b0, total_q} + 33'd65534;
    q0 = dx[32:16];
    r0 = 18'(dx[15:0]) + 18'(q0);
    q1 = q0; r1 = r0;
    if (r0 >= 18'd65535) begin
      q1 = q0 + 17'd1;
      r1 = r0 - 18'd65535;
    end
    q2 = (r1 >= 18'd65535) ? q1 + 17'd1 : q1;
  end

  // Adler-32 step on the current data byte
  always_comb begin
    lo_sum = {1'b0, lo_q} + {9'h0, db};
    lo_n   = (lo_sum >= AdlerMod) ? 16'(lo_sum - AdlerMod) : lo_sum[15:0];
    hi_sum = {1'b0, hi_q} + {1'b0, lo_n};
    hi_n   = (hi_sum >= AdlerMod) ? 16'(hi_sum - AdlerMod) : hi_sum[15:0];
  end

  assign col_inc = {1'b0, col_q} + 17'd1;

  always_comb begin
    state_d = state_q; idx_d = idx_q; j_d = j_q; pix_d = pix_q;
    fw_d = fw_q; fh_d = fh_q; total_d = total_q; blocks_d = blocks_q; idat_d = idat_q;
    crc_d = crc_q; lo_d = lo_q; hi_d = hi_q; col_d = col_q; blk_d = blk_q;
    strm_d = strm_q; act_d = act_q;
    oval_d = oval_q && !pop; ow_d = ow_q;
    cmd_take_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          if (cmd_i.kind == CMD_START) begin
            if (image_width_i == 13'd0) fw_d = 16'd1;
            else if ({4'h0, image_width_i} > 17'(MAX_WIDTH)) fw_d = 16'(MAX_WIDTH);
            else fw_d = {3'h0, image_width_i};
            if (image_height_i == 13'd0) fh_d = 16'd1;
            else if ({4'h0, image_height_i} > 17'(MAX_HEIGHT)) fh_d = 16'(MAX_HEIGHT);
            else fh_d = {3'h0, image_height_i};
            state_d = ST_MUL;
          end else if (act_q) begin
            pix_d   = cmd_i.pixel;
            j_d     = (col_q == 16'd0) ? 3'd0 : 3'd1;
            state_d = ST_DATA;
          end
        end
      end
      ST_MUL: begin
        total_d = {16'h0, fh_q} * ({14'h0, fw_q, 2'b00} + 32'd1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        blocks_d = q2;
        state_d  = ST_LEN;
      end
      ST_LEN: begin
        idat_d  = 32'd6 + total_q + {13'h0, blocks_q, 2'b00} + {15'h0, blocks_q};
        idx_d   = 6'd0;
        state_d = ST_HDR;
      end
      ST_HDR: begin
        if (out_free) begin
          oval_d = 1'b1;
          ow_d   = '{out_byte: hb, last_of_run: (idx_q == 6'd42), end_of_image: 1'b0};
          if (idx_q == 6'd12 || idx_q == 6'd37) crc_d = crc_byte(CrcInit, hb);
          else if ((idx_q > 6'd12 && idx_q <= 6'd28) || idx_q > 6'd37)
            crc_d = crc_byte(crc_q, hb);
          idx_d = idx_q + 6'd1;
          if (idx_q == 6'd42) begin
            lo_d = 16'd1; hi_d = 16'd0; col_d = 16'd0; blk_d = 16'd0;
            strm_d = total_q; act_d = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (blk_q == 16'd0) begin
          idx_d   = 6'd0;
          state_d = ST_BLK;
        end else if (out_free) begin
          oval_d = 1'b1;
          ow_d   = '{out_byte: db,
                     last_of_run: (j_q == 3'd4) && (strm_q != 32'd1),
                     end_of_image: 1'b0};
          crc_d  = crc_byte(crc_q, db);
          lo_d   = lo_n;
          hi_d   = hi_n;
          blk_d  = blk_q - 16'd1;
          strm_d = strm_q - 32'd1;
          j_d    = j_q + 3'd1;
          if (j_q == 3'd4) begin
            col_d = (col_inc >= {1'b0, fw_q}) ? 16'd0 : col_inc[15:0];
            idx_d = 6'd0;
            state_d = (strm_q == 32'd1) ? ST_END : ST_IDLE;
          end
        end
      end
      ST_BLK: begin
        if (out_free) begin
          oval_d = 1'b1;
          ow_d   = '{out_byte: bb, last_of_run: 1'b0, end_of_image: 1'b0};
          crc_d  = crc_byte(crc_q, bb);
          idx_d  = idx_q + 6'd1;
          if (idx_q == 6'd4) begin
            blk_d   = blen;
            state_d = ST_DATA;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          oval_d = 1'b1;
          ow_d   = '{out_byte: eb, last_of_run: (idx_q == 6'd19),
                     end_of_image: (idx_q == 6'd19)};
          if (idx_q < 6'd4) crc_d = crc_byte(crc_q, eb);
          else if (idx_q == 6'd12) crc_d = crc_byte(CrcInit, eb);
          else if (idx_q > 6'd12 && idx_q < 6'd16) crc_d = crc_byte(crc_q, eb);
          idx_d = idx_q + 6'd1;
          if (idx_q == 6'd19) begin
            act_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 6'd0;
      j_q     <= 3'd0;
      crc_q   <= CrcInit;
      lo_q    <= 16'd1;
      hi_q    <= 16'd0;
      col_q   <= 16'd0;
      blk_q   <= 16'd0;
      strm_q  <= 32'd0;
      act_q   <= 1'b0;
      oval_q  <= 1'b0;
      fw_q    <= 16'd1;
      fh_q    <= 16'd1;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      j_q     <= j_d;
      crc_q   <= crc_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      col_q   <= col_d;
      blk_q   <= blk_d;
      strm_q  <= strm_d;
      act_q   <= act_d;
      oval_q  <= oval_d;
      fw_q    <= fw_d;
      fh_q    <= fh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q    <= pix_d;
    total_q  <= total_d;
    blocks_q <= blocks_d;
    idat_q   <= idat_d;
    ow_q     <= ow_d;
  end

endmodule
`default_nettype wire

// File: sv/png_stored_rgba_encoder_top.sv
// PNG encoder for RGBA8 images, stored (uncompressed) DEFLATE blocks.
// Input queue: push a word when full is low. kind 0 opens a frame, kind 1
//   carries one pixel (R in 7:0 ... A in 31:24). Pixels with no open frame
//   are dropped silently.
// Output queue: while empty is low, out_word_o holds the next file byte;
//   pop takes it. last_of_run flags the final byte caused by one input
//   word, end_of_image the final byte of the file.
// Config: APB, image_width at 0x0, image_height at 0x4 (13 bits each),
//   sampled when a frame starts; write only while the block is idle.
// Timing: the output engine sends one byte per cycle while the receiver pops.
//   A start word is dispatched, runs the IDAT length math (multiply, divide
//   and length states) and sends 43 header bytes. A pixel word is dispatched
//   and sends four bytes, plus a row's filter byte, the five-byte header of a
//   new stored block and the 20-byte trailer after the last pixel.
// A two-word queue decouples the input side from the byte engine, and the
//   output register holds the last byte until it is popped.
// When the receiver stalls, the engine holds and the input queue fills.
// Reset empties both queues, closes any frame and sets both dimensions to 1.
`default_nettype none
module png_stored_rgba_encoder_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push,
  output logic                  full,
  input  pngenc_pkg::in_word_t  in_word_i,
  output logic                  empty,
  input  wire                   pop,
  output pngenc_pkg::out_word_t out_word_o,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [2:0]            paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import pngenc_pkg::*;

  logic [12:0] width_q, height_q;
  logic        cmd_valid, cmd_take;
  cmd_t        cmd;

  assign pready = 1'b1;
  assign prdata = {19'h0, paddr[2] ? height_q : width_q};

  // register file: address bit 2 picks the register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1;
      height_q <= 13'd1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) height_q <= pwdata[12:0];
      else width_q <= pwdata[12:0];
    end
  end

  pngenc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  pngenc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_take_o     (cmd_take),
    .empty          (empty),
    .pop            (pop),
    .out_word_o     (out_word_o)
  );

endmodule
`default_nettype wire
